FILE: rtl/core/tcw_pkg.sv
// shared constants, codes and types for the text console writer
package tcw_pkg;

    // screen geometry
    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int NCELLS = COLS * ROWS;
    localparam int CELL_W = $clog2(NCELLS);
    localparam int COL_W  = $clog2(COLS);

    // port field widths
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int RC_W   = 11;
    localparam int CUR_W  = 11;
    localparam int WORD_W = CHAR_W + ATTR_W;

    // special characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_BLANK   = 8'h00;
    localparam logic [WORD_W-1:0] BLANK_CELL   = {ATTR_BLANK, CH_SPACE};

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_SCR_PRIME,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic sweep_init;
        logic blank_step;
        logic cursor_home;
        logic put_exec;
        logic rd_issue;
        logic scroll_read;
        logic scroll_step;
        logic finish;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            put_wrap;
        logic            idx_last;
        logic            idx_scroll_last;
    } t_dp_stat;

endpackage

FILE: rtl/core/tcw_datapath.sv
// datapath of the text console writer: screen store, cursor, sweep counter, result registers
module tcw_datapath
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [OP_W-1:0]   i_op,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ATTR_W-1:0] i_attr,
    input  logic [RC_W-1:0]   i_read_cell,
    output logic [CUR_W-1:0]  o_cursor_cell,
    output logic [CHAR_W-1:0] o_cell_char,
    output logic [ATTR_W-1:0] o_cell_attr
);

    // screen store
    logic [WORD_W-1:0] r_mem [NCELLS];
    logic [WORD_W-1:0] r_rdata;

    // latched transaction
    logic [OP_W-1:0]   r_op;
    logic [CHAR_W-1:0] r_ch;
    logic [ATTR_W-1:0] r_at;
    logic [RC_W-1:0]   r_rc;
    logic              r_rd_ok;

    // cursor and sweep counter
    logic [CELL_W-1:0] r_cur, n_cur;
    logic [COL_W-1:0]  r_col, n_col;
    logic [CELL_W-1:0] r_idx, n_idx;

    // memory port controls
    logic              mem_we;
    logic [CELL_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [CELL_W-1:0] mem_raddr;

    // put evaluation
    logic [CELL_W:0]   put_next;
    logic [COL_W-1:0]  put_col;
    logic              put_we;
    logic [CELL_W-1:0] put_addr;
    logic [WORD_W-1:0] put_data;
    logic              put_wrap;
    logic [CELL_W:0]   scr_raddr;

    // latch inputs on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_ch    <= i_char_code;
            r_at    <= i_attr;
            r_rc    <= i_read_cell;
            r_rd_ok <= (i_op == OP_READ) && ({1'b0, i_read_cell} < (RC_W+1)'(NCELLS));
        end
    end

    // put character: newline, backspace, or plain write
    always_comb begin
        put_we   = 1'b0;
        put_addr = r_cur;
        put_data = {r_at, r_ch};
        put_next = {1'b0, r_cur};
        put_col  = r_col;
        if (r_ch == CH_NEWLINE) begin
            put_next = {1'b0, r_cur} - (CELL_W+1)'(r_col) + (CELL_W+1)'(COLS);
            put_col  = '0;
        end else if (r_ch == CH_BACKSPACE) begin
            if (r_cur != '0) begin
                put_we   = 1'b1;
                put_addr = r_cur - 1'b1;
                put_data = {r_at, CH_SPACE};
                put_next = {1'b0, r_cur} - 1'b1;
                put_col  = (r_col == '0) ? COL_W'(COLS - 1) : r_col - 1'b1;
            end
        end else begin
            put_we   = 1'b1;
            put_next = {1'b0, r_cur} + 1'b1;
            put_col  = (r_col == COL_W'(COLS - 1)) ? '0 : r_col + 1'b1;
        end
        put_wrap = (put_next >= (CELL_W+1)'(NCELLS));
    end

    // cursor and counter next values
    always_comb begin
        n_cur = r_cur;
        n_col = r_col;
        n_idx = r_idx;
        if (i_cmd.cursor_home) begin
            n_cur = '0;
            n_col = '0;
        end
        if (i_cmd.put_exec) begin
            if (put_wrap) begin
                n_cur = CELL_W'(NCELLS - COLS);
                n_col = '0;
                n_idx = '0;
            end else begin
                n_cur = put_next[CELL_W-1:0];
                n_col = put_col;
            end
        end
        if (i_cmd.sweep_init) begin
            n_idx = '0;
        end else if (i_cmd.blank_step || i_cmd.scroll_step) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
            r_col <= '0;
            r_idx <= '0;
        end else begin
            r_cur <= n_cur;
            r_col <= n_col;
            r_idx <= n_idx;
        end
    end

    // memory port selection
    assign scr_raddr = {1'b0, r_idx} + (CELL_W+1)'(COLS) + (CELL_W+1)'(i_cmd.scroll_step);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = BLANK_CELL;
        if (i_cmd.blank_step) begin
            mem_we = 1'b1;
        end else if (i_cmd.scroll_step) begin
            mem_we    = 1'b1;
            mem_wdata = r_rdata;
        end else if (i_cmd.put_exec) begin
            mem_we    = put_we;
            mem_waddr = put_addr;
            mem_wdata = put_data;
        end
        mem_re    = 1'b0;
        mem_raddr = scr_raddr[CELL_W-1:0];
        if (i_cmd.rd_issue) begin
            mem_re    = r_rd_ok;
            mem_raddr = r_rc[CELL_W-1:0];
        end else if (i_cmd.scroll_read || i_cmd.scroll_step) begin
            mem_re = (scr_raddr < (CELL_W+1)'(NCELLS));
        end
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_cursor_cell <= CUR_W'(r_cur);
            o_cell_char   <= r_rd_ok ? r_rdata[CHAR_W-1:0] : '0;
            o_cell_attr   <= r_rd_ok ? r_rdata[WORD_W-1:CHAR_W] : '0;
        end
    end

    // status to controller
    assign o_stat.op              = r_op;
    assign o_stat.put_wrap        = put_wrap;
    assign o_stat.idx_last        = (r_idx == CELL_W'(NCELLS - 1));
    assign o_stat.idx_scroll_last = (r_idx == CELL_W'(NCELLS - COLS - 1));

endmodule

FILE: rtl/core/tcw_ctrl.sv
// controller state machine of the text console writer
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output logic     o_done,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_state r_state, n_state;
    logic   r_done;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (i_stat.idx_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (i_stat.op)
                    OP_PUT:   n_state = i_stat.put_wrap ? ST_SCR_PRIME : ST_DONE;
                    OP_CLEAR: n_state = ST_CLEAR;
                    default:  n_state = ST_DONE;
                endcase
            end
            ST_CLEAR: begin
                if (i_stat.idx_last) n_state = ST_DONE;
            end
            ST_SCR_PRIME: n_state = ST_SCROLL;
            ST_SCROLL: begin
                if (i_stat.idx_scroll_last) n_state = ST_FILL;
            end
            ST_FILL: begin
                if (i_stat.idx_last) n_state = ST_DONE;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_INIT:  o_cmd.blank_step = 1'b1;
            ST_IDLE:  o_cmd.load = start;
            ST_EXEC: begin
                unique case (i_stat.op)
                    OP_PUT: o_cmd.put_exec = 1'b1;
                    OP_CLEAR: begin
                        o_cmd.sweep_init  = 1'b1;
                        o_cmd.cursor_home = 1'b1;
                    end
                    OP_READ: o_cmd.rd_issue = 1'b1;
                    default: o_cmd = '0;
                endcase
            end
            ST_CLEAR:     o_cmd.blank_step  = 1'b1;
            ST_SCR_PRIME: o_cmd.scroll_read = 1'b1;
            ST_SCROLL:    o_cmd.scroll_step = 1'b1;
            ST_FILL:      o_cmd.blank_step  = 1'b1;
            ST_DONE:      o_cmd.finish      = 1'b1;
            default:      o_cmd = '0;
        endcase
    end

    // state and strobe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_DONE);
        end
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;

endmodule

FILE: rtl/core/text_console_writer_core.sv
// top level of the text console writer: controller plus datapath
// put character: states EXEC and DONE, then the result strobe; next start taken while the strobe is high
// scroll on wrap adds a priming read, then one store cell moved up per cycle, then the bottom row blanked
// clear screen: one store cell blanked per cycle
// read one cell: limited by the registered store read
// reset: busy while a clearing pass blanks the store; results never stall
module text_console_writer_core
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_op,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ATTR_W-1:0] i_attr,
    input  logic [RC_W-1:0]   i_read_cell,
    output logic              o_done,
    output logic [CUR_W-1:0]  o_cursor_cell,
    output logic [CHAR_W-1:0] o_cell_char,
    output logic [ATTR_W-1:0] o_cell_attr
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencing
    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // store, cursor and results
    tcw_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_op          (i_op),
        .i_char_code   (i_char_code),
        .i_attr        (i_attr),
        .i_read_cell   (i_read_cell),
        .o_cursor_cell (o_cursor_cell),
        .o_cell_char   (o_cell_char),
        .o_cell_attr   (o_cell_attr)
    );

endmodule

FILE: rtl/core/tcw_checker.sv
// port-level checks for the text console writer, bound to the top level
module tcw_checker
    import tcw_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input logic [CUR_W-1:0] o_cursor_cell
);

    // reset starts the clearing pass
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("not busy after reset");

    // an accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // a result only follows busy work
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a transaction in progress");

    // cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_cursor_cell < CUR_W'(NCELLS)))
        else $error("cursor beyond last cell");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_cursor_cell (o_cursor_cell)
);

FILE: tb/text_console_writer_core_test.sv
// self-checking testbench for the text console writer core
module text_console_writer_core_test;
    import tcw_pkg::*;

    // op code that the block has no use for
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 400;
    localparam int MAX_SHOWN    = 10;
    localparam int TAIL_CYCLES  = NCELLS + COLS + 200;
    localparam int DRAIN_LIMIT  = 40 * NCELLS;

    // one expected result transaction
    typedef struct {
        logic [CUR_W-1:0]  cursor;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] at;
    } t_console_report;

    // tracks the screen and cursor and checks the reports that come back
    class t_console_scoreboard;
        logic [WORD_W-1:0] screen[NCELLS];
        int unsigned       cursor_pos;
        t_console_report   expected_reports[$];
        int                errors;

        function new();
            blank_screen();
            cursor_pos = 0;
            errors     = 0;
        endfunction

        function void blank_screen();
            for (int i = 0; i < NCELLS; i++) screen[i] = BLANK_CELL;
        endfunction

        function void scroll_screen();
            for (int i = 0; i < NCELLS - COLS; i++) screen[i] = screen[i + COLS];
            for (int i = NCELLS - COLS; i < NCELLS; i++) screen[i] = BLANK_CELL;
            cursor_pos = NCELLS - COLS;
        endfunction

        function void write_char(logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] at);
            if (cursor_pos >= NCELLS) cursor_pos = 0;
            if (ch == CH_NEWLINE) begin
                cursor_pos = (cursor_pos / COLS + 1) * COLS;
            end else if (ch == CH_BACKSPACE) begin
                // nothing to erase at the top left cell
                if (cursor_pos != 0) begin
                    cursor_pos--;
                    screen[cursor_pos] = {at, CH_SPACE};
                end
            end else begin
                screen[cursor_pos] = {at, ch};
                cursor_pos++;
            end
            if (cursor_pos >= NCELLS) scroll_screen();
        endfunction

        // predict the report of an accepted command transaction
        function void note_command(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                   logic [ATTR_W-1:0] at, logic [RC_W-1:0] rc);
            t_console_report rep;
            rep.ch = '0;
            rep.at = '0;
            case (op)
                OP_PUT: begin
                    write_char(ch, at);
                end
                OP_CLEAR: begin
                    blank_screen();
                    cursor_pos = 0;
                end
                OP_READ: begin
                    if (rc < NCELLS) begin
                        rep.ch = screen[rc][CHAR_W-1:0];
                        rep.at = screen[rc][WORD_W-1:CHAR_W];
                    end
                end
                default: ;
            endcase
            rep.cursor = cursor_pos[CUR_W-1:0];
            expected_reports.push_back(rep);
        endfunction

        // compare a report transaction with the oldest prediction
        function void check_report(logic [CUR_W-1:0] cursor, logic [CHAR_W-1:0] ch,
                                   logic [ATTR_W-1:0] at);
            t_console_report exp_rep;
            if (expected_reports.size() == 0) begin
                if (errors < MAX_SHOWN)
                    $display("unexpected report: cursor %0d char %02h attr %02h",
                             cursor, ch, at);
                errors++;
                return;
            end
            exp_rep = expected_reports.pop_front();
            if (cursor !== exp_rep.cursor || ch !== exp_rep.ch || at !== exp_rep.at) begin
                if (errors < MAX_SHOWN)
                    $display("report differs: cursor %0d/%0d char %02h/%02h attr %02h/%02h",
                             exp_rep.cursor, cursor, exp_rep.ch, ch, exp_rep.at, at);
                errors++;
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   i_op        = OP_PUT;
    logic [CHAR_W-1:0] i_char_code = '0;
    logic [ATTR_W-1:0] i_attr      = '0;
    logic [RC_W-1:0]   i_read_cell = '0;
    logic              o_done;
    logic [CUR_W-1:0]  o_cursor_cell;
    logic [CHAR_W-1:0] o_cell_char;
    logic [ATTR_W-1:0] o_cell_attr;

    t_console_scoreboard sb = new();
    int items_sent = 0;
    int burst_left = 0;

    text_console_writer_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_char_code   (i_char_code),
        .i_attr        (i_attr),
        .i_read_cell   (i_read_cell),
        .o_done        (o_done),
        .o_cursor_cell (o_cursor_cell),
        .o_cell_char   (o_cell_char),
        .o_cell_attr   (o_cell_attr)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watch both sides of the block
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && busy === 1'b0)
                sb.note_command(i_op, i_char_code, i_attr, i_read_cell);
            if (o_done === 1'b1)
                sb.check_report(o_cursor_cell, o_cell_char, o_cell_attr);
        end
    end

    // overall time limit
    initial begin
        #60_000_000;
        $display("text_console_writer_core: mismatch");
        $finish;
    end

    // hold start low for a number of cycles
    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // stop sending until every prediction has been matched
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    // send one command transaction, with bursts and gaps in between
    task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                             input logic [ATTR_W-1:0] at, input logic [RC_W-1:0] rc);
        if (burst_left == 0) begin
            if ($urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(40, 90);
            end else begin
                burst_left = $urandom_range(1, 12);
                hold_off($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 14));
            end
        end
        burst_left--;
        start       <= 1'b1;
        i_op        <= op;
        i_char_code <= ch;
        i_attr      <= at;
        i_read_cell <= rc;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch, input logic [ATTR_W-1:0] at);
        send_item(OP_PUT, ch, at, RC_W'($urandom));
    endtask

    task automatic read_cell(input logic [RC_W-1:0] rc);
        send_item(OP_READ, CHAR_W'($urandom), ATTR_W'($urandom), rc);
    endtask

    // a line of text with random content, mostly ended by a newline
    task automatic type_line();
        int len;
        logic [CHAR_W-1:0] ch;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 85) : $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 19))
                0:       ch = CH_BACKSPACE;
                1, 2:    ch = CHAR_W'($urandom);
                default: ch = CHAR_W'($urandom_range(32, 126));
            endcase
            put_char(ch, ATTR_W'($urandom));
        end
        if ($urandom_range(0, 9) != 0) put_char(CH_NEWLINE, ATTR_W'($urandom));
    endtask

    // stimulus
    initial begin
        int sel;
        int run;
        int done_wait;
        bit timed_out;
        timed_out = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        read_cell(0);
        put_char(CH_BACKSPACE, 8'hFF);
        put_char(8'hFF, 8'hFF);
        put_char(8'h00, 8'h00);
        read_cell(0);
        read_cell(1);
        put_char(CH_NEWLINE, 8'h0F);
        put_char(CH_BACKSPACE, 8'h5A);
        read_cell(RC_W'(COLS - 1));
        read_cell(RC_W'(NCELLS - 1));
        read_cell(RC_W'(NCELLS));
        read_cell('1);
        send_item(OP_UNUSED, '1, '1, '1);
        send_item(OP_UNUSED, '0, '0, '0);
        send_item(OP_CLEAR, '1, '1, '1);
        read_cell(0);
        read_cell(RC_W'(COLS - 1));
        put_char(8'h41, 8'h0F);
        drain();

        // random part
        while (items_sent < 18 + RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                type_line();
            end else if (sel < 68) begin
                run = (sb.cursor_pos > 2) ? sb.cursor_pos - $urandom_range(1, 3) : 0;
                read_cell(RC_W'(run));
            end else if (sel < 78) begin
                read_cell(($urandom_range(0, 4) == 0) ? RC_W'($urandom_range(NCELLS, 2047))
                                                      : RC_W'($urandom_range(0, NCELLS - 1)));
            end else if (sel < 86) begin
                run = $urandom_range(1, 5);
                repeat (run) put_char(CH_BACKSPACE, ATTR_W'($urandom));
            end else if (sel < 92) begin
                run = $urandom_range(1, 30);
                repeat (run) put_char(CH_NEWLINE, ATTR_W'($urandom));
            end else if (sel < 95) begin
                send_item(OP_CLEAR, CHAR_W'($urandom), ATTR_W'($urandom), RC_W'($urandom));
            end else if (sel < 97) begin
                send_item(OP_UNUSED, CHAR_W'($urandom), ATTR_W'($urandom), RC_W'($urandom));
            end else begin
                drain();
            end
        end

        // wait for the last reports, then watch for strays
        start <= 1'b0;
        done_wait = 0;
        while (sb.pending() > 0 && done_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            done_wait++;
        end
        if (sb.pending() > 0) timed_out = 1'b1;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0 && !timed_out) begin
            $display("text_console_writer_core: match");
        end else begin
            $display("text_console_writer_core: mismatch");
        end
        $finish;
    end

endmodule
